// ----- sv/rra_pkg.sv -----
// rra_pkg: shared constants and types for the round-robin burst arbiter.
// No dependencies; used by the interfaces, the lane, merge and top modules.
package rra_pkg;

  localparam int MAX_REQUESTERS = 16;
  localparam int IDX_W = $clog2(MAX_REQUESTERS);
  localparam int CNT_W = 5;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  // arbitration mode codes
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BURST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARB_MODE        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_COUNT = 4'd1;

  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_RR;
  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_REQUESTERS);

  typedef logic [MAX_REQUESTERS-1:0] req_vec_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  // per-lane findings passed to the merge stage
  typedef struct packed {
    logic elig;   // requesting and inside the candidate count
    logic upper;  // eligible and at or after the search start
  } lane_flags_t;

  typedef lane_flags_t [MAX_REQUESTERS-1:0] lane_vec_t;

  // merge result
  typedef struct packed {
    logic found;
    idx_t win;
  } pick_t;

endpackage

// ----- sv/rra_ifs.sv -----
// rra_ifs: valid/ready channel interfaces for requests, grants and config writes.
// Depends on rra_pkg.
interface rra_req_if;
  logic                 valid;
  logic                 ready;
  rra_pkg::req_vec_t    request_vector;
  rra_pkg::req_vec_t    last_vector;
  modport source (output valid, output request_vector, output last_vector, input ready);
  modport sink   (input valid, input request_vector, input last_vector, output ready);
endinterface

interface rra_grant_if;
  logic          valid;
  logic          ready;
  logic          grant_valid;
  rra_pkg::idx_t grant_index;
  modport source (output valid, output grant_valid, output grant_index, input ready);
  modport sink   (input valid, input grant_valid, input grant_index, output ready);
endinterface

interface rra_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rra_pkg::CFG_IDX_W-1:0]    index;
  logic [rra_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/rra_lane.sv -----
// rra_lane: per-candidate qualifier, one instance per requester.
// Depends on rra_pkg.
module rra_lane (
  input  rra_pkg::idx_t       lane_idx,
  input  logic                req,
  input  rra_pkg::cnt_t       used_cnt,
  input  rra_pkg::idx_t       start_idx,
  output rra_pkg::lane_flags_t flags
);

  logic in_range;

  assign in_range    = {1'b0, lane_idx} < used_cnt;
  assign flags.elig  = req && in_range;
  assign flags.upper = req && in_range && (lane_idx >= start_idx);

endmodule

// ----- sv/rra_merge.sv -----
// rra_merge: combines lane flags into one winner; wrapped search first takes
// the lowest index at or above the start, else the lowest eligible index.
// Depends on rra_pkg.
module rra_merge (
  input  rra_pkg::lane_vec_t lanes,
  output rra_pkg::pick_t     pick
);

  logic          any_upper;
  logic          any_elig;
  rra_pkg::idx_t upper_idx;
  rra_pkg::idx_t elig_idx;

  always_comb begin
    any_upper = 1'b0;
    any_elig  = 1'b0;
    upper_idx = '0;
    elig_idx  = '0;
    // scan downward so the lowest index wins
    for (int i = rra_pkg::MAX_REQUESTERS - 1; i >= 0; i--) begin
      if (lanes[i].upper) begin
        any_upper = 1'b1;
        upper_idx = rra_pkg::IDX_W'(i);
      end
      if (lanes[i].elig) begin
        any_elig = 1'b1;
        elig_idx = rra_pkg::IDX_W'(i);
      end
    end
    pick.found = any_elig;
    pick.win   = any_upper ? upper_idx : elig_idx;
  end

endmodule

// ----- sv/round_robin_burst_arbiter.sv -----
// round_robin_burst_arbiter: top level, one grant per request beat.
// The grant beat is registered and shows in the cycle after the request beat is accepted.
// Throughput: one beat per cycle while the grant side keeps taking beats; the lane
// compare and priority merge feed the winner register back combinationally.
// Reset (rst_n low, synchronous): mode round robin, count 16, no prior winner,
// output register empty. Depends on rra_pkg, rra_ifs, rra_lane, rra_merge.
module round_robin_burst_arbiter (
  input  logic clk,
  input  logic rst_n,
  rra_req_if.sink     in_req,
  rra_grant_if.source out_grant,
  rra_cfg_if.sink     cfg_wr
);

  // ---------------------------------------------------------------
  // Configuration registers. Writes should land only while idle; the block does not enforce it.
  // ---------------------------------------------------------------
  logic [rra_pkg::MODE_W-1:0] arb_mode_r;
  rra_pkg::cnt_t              cand_cnt_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arb_mode_r <= rra_pkg::MODE_RESET;
      cand_cnt_r <= rra_pkg::COUNT_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        rra_pkg::REG_ARB_MODE:
          arb_mode_r <= cfg_wr.data[rra_pkg::MODE_W-1:0];
        rra_pkg::REG_CANDIDATE_COUNT:
          cand_cnt_r <= cfg_wr.data[rra_pkg::CNT_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Arbitration state: last winner, whether any grant was made, and
  // whether the last burst-mode grant was a last beat.
  // ---------------------------------------------------------------
  rra_pkg::idx_t prior_win_r;
  logic          prior_vld_r;
  logic          burst_done_r;

  // Mode 3 is unused and behaves as plain round robin.
  logic [rra_pkg::MODE_W-1:0] eff_mode;
  assign eff_mode = (arb_mode_r == rra_pkg::MODE_FIXED ||
                     arb_mode_r == rra_pkg::MODE_BURST) ? arb_mode_r : rra_pkg::MODE_RR;

  // Saturate the count at the number of lanes.
  rra_pkg::cnt_t used_cnt;
  assign used_cnt = (cand_cnt_r > rra_pkg::CNT_W'(rra_pkg::MAX_REQUESTERS)) ?
                    rra_pkg::CNT_W'(rra_pkg::MAX_REQUESTERS) : cand_cnt_r;

  // Search start. Fixed priority, no grant yet, or a winner outside a
  // lowered count all start at 0. Burst mode restarts at the winner until
  // its last beat was granted; otherwise start one past it, wrapping.
  rra_pkg::idx_t start_idx;
  rra_pkg::cnt_t next_slot;
  assign next_slot = {1'b0, prior_win_r} + rra_pkg::CNT_W'(1);

  always_comb begin
    start_idx = '0;
    if (eff_mode != rra_pkg::MODE_FIXED && prior_vld_r &&
        ({1'b0, prior_win_r} < used_cnt)) begin
      if (eff_mode == rra_pkg::MODE_BURST && !burst_done_r) begin
        start_idx = prior_win_r;
      end else if (next_slot >= used_cnt) begin
        start_idx = '0;
      end else begin
        start_idx = next_slot[rra_pkg::IDX_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------
  // Lanes: one qualifier per candidate, then the merge.
  // ---------------------------------------------------------------
  rra_pkg::lane_vec_t lane_flags;
  rra_pkg::pick_t     pick;

  for (genvar gv = 0; gv < rra_pkg::MAX_REQUESTERS; gv++) begin : g_lane
    rra_lane u_lane (
      .lane_idx  (rra_pkg::IDX_W'(gv)),
      .req       (in_req.request_vector[gv]),
      .used_cnt  (used_cnt),
      .start_idx (start_idx),
      .flags     (lane_flags[gv])
    );
  end

  rra_merge u_merge (
    .lanes (lane_flags),
    .pick  (pick)
  );

  // ---------------------------------------------------------------
  // Handshake: the output register frees up when taken, so a new beat
  // enters in the same cycle the previous grant leaves.
  // ---------------------------------------------------------------
  logic out_vld_r;
  logic grant_vld_r;
  rra_pkg::idx_t grant_idx_r;
  logic accept;

  assign in_req.ready = !out_vld_r || out_grant.ready;
  assign accept       = in_req.valid && in_req.ready;

  logic out_vld_nxt;
  assign out_vld_nxt = accept || (out_vld_r && !out_grant.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      prior_win_r  <= '0;
      prior_vld_r  <= 1'b0;
      burst_done_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (accept && pick.found) begin
        prior_win_r <= pick.win;
        prior_vld_r <= 1'b1;
        if (eff_mode == rra_pkg::MODE_BURST) begin
          burst_done_r <= in_req.last_vector[pick.win];
        end
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      grant_vld_r <= pick.found;
      grant_idx_r <= pick.found ? pick.win : '0;
    end
  end

  assign out_grant.valid       = out_vld_r;
  assign out_grant.grant_valid = grant_vld_r;
  assign out_grant.grant_index = grant_idx_r;

endmodule

// ----- tb/grant_checker.sv -----
// grant_checker: watches the request, grant and config channels of the arbiter,
// predicts every grant beat and compares it field by field.
// Depends on rra_pkg and rra_ifs.
module grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  rra_req_if          req_ch,
  rra_grant_if        grant_ch,
  rra_cfg_if          cfg_ch,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;

  typedef struct packed {
    logic granted;
    idx_t index;
  } grant_t;

  grant_t            expected_grants[$];
  logic [MODE_W-1:0] mode_q;
  cnt_t              count_q;
  idx_t              last_winner;
  logic              winner_known;
  logic              burst_done;

  // Arbitrate one request beat and advance the winner state.
  function automatic grant_t next_grant(req_vec_t req, req_vec_t last);
    int     n;
    int     start;
    int     pos;
    int     k;
    grant_t g;
    n     = (int'(count_q) > MAX_REQUESTERS) ? MAX_REQUESTERS : int'(count_q);
    start = 0;
    g     = '0;
    // unused mode code behaves as plain round robin
    if (mode_q != MODE_FIXED && winner_known && int'(last_winner) < n) begin
      if (mode_q == MODE_BURST && !burst_done) begin
        start = int'(last_winner);
      end else begin
        start = (int'(last_winner) + 1 >= n) ? 0 : int'(last_winner) + 1;
      end
    end
    for (k = 0; k < n; k++) begin
      pos = start + k;
      if (pos >= n) pos -= n;
      if (!g.granted && req[pos]) begin
        g.granted = 1'b1;
        g.index   = idx_t'(pos);
      end
    end
    if (g.granted) begin
      last_winner  = g.index;
      winner_known = 1'b1;
      if (mode_q == MODE_BURST) burst_done = last[g.index];
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      mode_q       = MODE_RESET;
      count_q      = COUNT_RESET;
      last_winner  = '0;
      winner_known = 1'b0;
      burst_done   = 1'b0;
      expected_grants.delete();
    end else begin
      if (grant_ch.valid && grant_ch.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: grant beat with none expected: grant_valid %0b grant_index %0d",
                   $time, grant_ch.grant_valid, grant_ch.grant_index);
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (grant_ch.grant_valid !== want.granted) begin
            $display("%0t: grant_valid expected %0b, actual %0b",
                     $time, want.granted, grant_ch.grant_valid);
            fail_count++;
          end
          if (grant_ch.grant_index !== want.index) begin
            $display("%0t: grant_index expected %0d, actual %0d",
                     $time, want.index, grant_ch.grant_index);
            fail_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ARB_MODE:        mode_q  = cfg_ch.data[MODE_W-1:0];
          REG_CANDIDATE_COUNT: count_q = cfg_ch.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready)
        expected_grants.push_back(next_grant(req_ch.request_vector, req_ch.last_vector));
    end
    pending = expected_grants.size();
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives request beats and register writes into the arbiter and
// gives the verdict. Depends on rra_pkg, rra_ifs, the arbiter RTL and grant_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  rra_req_if   req_ch ();
  rra_grant_if grant_ch ();
  rra_cfg_if   cfg_ch ();

  int fail_count;
  int pending_grants;

  // per-phase knobs shared by the driver processes
  bit       sender_gaps   = 1'b0;
  bit       receiver_gaps = 1'b0;
  bit       hold_off_req  = 1'b0;  // asks the grant side for one long stall
  req_vec_t live_requests = '0;    // requesters that persist across beats
  cnt_t     count_now     = COUNT_RESET;

  always #4 clk = ~clk;

  round_robin_burst_arbiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_grant (grant_ch),
    .cfg_wr    (cfg_ch)
  );

  grant_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ch     (req_ch),
    .grant_ch   (grant_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending_grants)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Bits of the candidates currently in use (count saturates at the maximum).
  function automatic req_vec_t in_use_mask(cnt_t c);
    req_vec_t m;
    int       i;
    m = '0;
    for (i = 0; i < MAX_REQUESTERS; i++) if (i < int'(c)) m[i] = 1'b1;
    return m;
  endfunction

  // Grant side: ready toggles at the falling edge. A hold-off request turns
  // into one long stall, counted here, while the sender keeps offering beats.
  initial begin
    int stall_left;
    grant_ch.ready = 1'b0;
    stall_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 160;
      end else if (stall_left == 0 && receiver_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        grant_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        grant_ch.ready <= 1'b1;
      end
    end
  end

  // One request beat; returns at the edge that accepts it. valid is only
  // lowered when a gap is inserted, never dropped and raised in one step.
  task automatic send_beat(req_vec_t req, req_vec_t last);
    int gap;
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.request_vector <= req;
    req_ch.last_vector    <= last;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop offering beats and wait until every grant has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending_grants == 0);
    repeat (3) @(negedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_CANDIDATE_COUNT) count_now = data[CNT_W-1:0];
  endtask

  // Random beat: persistent requester sets dominate so the round-robin and
  // burst pointers get exercised; the rest is noise, empty, full and one- or two-bit vectors.
  task automatic random_beat();
    req_vec_t req;
    req_vec_t last;
    case ($urandom_range(0, 9))
      0: req = req_vec_t'($urandom);
      1: req = '0;
      2: req = '1;
      3, 4, 5, 6: begin
        live_requests ^= req_vec_t'(1) << $urandom_range(0, MAX_REQUESTERS - 1);
        if ($urandom_range(0, 5) == 0) live_requests = req_vec_t'($urandom);
        req = live_requests;
      end
      default: begin
        req = req_vec_t'(1) << $urandom_range(0, MAX_REQUESTERS - 1);
        if ($urandom_range(0, 1) == 1)
          req |= req_vec_t'(1) << $urandom_range(0, MAX_REQUESTERS - 1);
      end
    endcase
    // mostly keep requests inside the active candidates, sometimes not
    if ($urandom_range(0, 3) != 0) req &= in_use_mask(count_now);
    last = ($urandom_range(0, 1) == 1) ? req_vec_t'($urandom)
                                       : req_vec_t'($urandom & $urandom);
    send_beat(req, last);
  endtask

  initial begin
    int                     phase;
    int                     item;
    logic [MODE_W-1:0]      mode_pick;
    cnt_t                   count_pick;
    logic [CFG_DATA_W-1:0]  data;

    rst_n                 = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.request_vector = '0;
    req_ch.last_vector    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset settings: round robin over 16 candidates ----
    send_beat('0, '0);                      // nothing requested
    send_beat('1, '0);                      // no prior winner: search from 0
    send_beat('1, '0);                      // next after 0
    send_beat(req_vec_t'(1) << (MAX_REQUESTERS - 1), '1);  // top candidate
    send_beat('1, '0);                      // wraps past the top to 0

    // fixed priority: lowest index always wins
    write_reg(REG_ARB_MODE, CFG_DATA_W'(MODE_FIXED));
    send_beat('1, '1);
    send_beat(~req_vec_t'(1), '0);
    send_beat(req_vec_t'(1) << (MAX_REQUESTERS - 1), '0);  // winner ends at 15

    // burst lock: stays on the winner until its beat is marked last
    write_reg(REG_ARB_MODE, CFG_DATA_W'(MODE_BURST));
    send_beat(req_vec_t'('b1010), '0);      // searches from 15, wraps to 1
    send_beat(req_vec_t'('b1010), '0);      // held on 1
    send_beat(req_vec_t'('b1010), req_vec_t'('b0010));  // 1 again, burst ends
    send_beat(req_vec_t'('b1010), '0);      // moves on to 3
    send_beat('0, '1);                      // idle beat keeps the lock state

    // unused mode code acts as round robin
    write_reg(REG_ARB_MODE, ~CFG_DATA_W'(MODE_FIXED));
    send_beat('1, '0);
    send_beat(req_vec_t'(1) << (MAX_REQUESTERS - 1), '0);

    // count lowered below the prior winner: search restarts at 0
    write_reg(REG_CANDIDATE_COUNT, CFG_DATA_W'(4));
    send_beat(~req_vec_t'('hF), '1);        // only requesters outside the count
    send_beat('1, '0);
    send_beat(req_vec_t'('b1000), '0);      // last in-use candidate
    send_beat('1, '0);                      // wraps to 0

    // count of zero: no candidate can win
    write_reg(REG_CANDIDATE_COUNT, '0);
    send_beat('1, '1);

    // count above the maximum saturates; upper data bits set as well
    write_reg(REG_CANDIDATE_COUNT, '1);
    send_beat('1, '0);
    send_beat(req_vec_t'(1) << (MAX_REQUESTERS - 1), '0);

    // single candidate
    write_reg(REG_CANDIDATE_COUNT, CFG_DATA_W'(1));
    send_beat('1, '0);
    send_beat('1, '1);

    // unmapped register index must change nothing
    write_reg('1, '1);
    write_reg(REG_ARB_MODE, CFG_DATA_W'(MODE_RR));
    write_reg(REG_CANDIDATE_COUNT, CFG_DATA_W'(MAX_REQUESTERS));

    // ---- random part: 13 phases of 50 beats, settings change between ----
    for (phase = 0; phase < 13; phase++) begin
      mode_pick = MODE_W'($urandom);
      case ($urandom_range(0, 5))
        0:       count_pick = cnt_t'(MAX_REQUESTERS);
        1:       count_pick = cnt_t'(1);
        2:       count_pick = cnt_t'($urandom_range(2, MAX_REQUESTERS - 1));
        3:       count_pick = ($urandom_range(0, 2) == 0) ? '0 : cnt_t'($urandom_range(
                                MAX_REQUESTERS + 1, (1 << CNT_W) - 1));
        default: count_pick = cnt_t'($urandom_range(1, MAX_REQUESTERS));
      endcase
      // burst mode gets extra weight since it has the most state
      if (phase % 3 == 0) mode_pick = MODE_BURST;
      data = CFG_DATA_W'(mode_pick);
      if ($urandom_range(0, 1) == 1) data |= CFG_DATA_W'($urandom) << MODE_W;
      write_reg(REG_ARB_MODE, data);
      data = CFG_DATA_W'(count_pick);
      if ($urandom_range(0, 1) == 1) data |= CFG_DATA_W'($urandom) << CNT_W;
      write_reg(REG_CANDIDATE_COUNT, data);

      // sender gaps except in every third phase, grant-side gaps except when phase % 4 is 1
      sender_gaps   = (phase % 3 != 0);
      receiver_gaps = (phase % 4 != 1);
      // long grant-side hold-off while beats keep coming: input must stall
      if (phase == 2 || phase == 8) begin
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
      end
      for (item = 0; item < 50; item++) random_beat();
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
